[sv/lmbcs_pkg.sv]
// Shared types, constants and lookup tables for the LMBCS byte-stream decoder.
package lmbcs_pkg;

  // Width of the saturating character counter.
  localparam int COUNT_BITS = 16;
  // Width of the visible count and of the storage limit.
  localparam int SHOW_BITS  = 16;
  // Width used when comparing the counter with 16-bit quantities.
  localparam int CMP_BITS   = (COUNT_BITS > SHOW_BITS) ? COUNT_BITS : SHOW_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [SHOW_BITS-1:0]  SHOW_MAX  = {SHOW_BITS{1'b1}};
  localparam logic [15:0]           LIMIT_RESET = 16'hFFFF;

  // Byte classes.
  localparam logic [7:0] BYTE_NUL        = 8'h00;
  localparam logic [7:0] BYTE_GRP1_PFX   = 8'h01;
  localparam logic [7:0] BYTE_PRINT_LO   = 8'h20;
  localparam logic [7:0] BYTE_PRINT_HI   = 8'h7F;
  localparam logic [7:0] CHAR_UNKNOWN    = 8'h3F;  // '?'

  // Decoder phase, one-hot.
  typedef enum logic [3:0] {
    PH_NORMAL = 4'b0001,
    PH_INDEX  = 4'b0010,
    PH_SKIP   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // One source beat held in the input register.
  typedef struct packed {
    logic [7:0] src_byte;
    logic       last_byte;
  } beat_t;

  // Result of decoding one beat.
  typedef struct packed {
    logic                 emit;
    logic [7:0]           out_char;
    logic                 char_valid;
    logic                 stored;
    logic                 is_final;
    logic [SHOW_BITS-1:0] char_count;
  } res_t;

  // Group-1 character map, indexed by byte value.
  localparam logic [7:0] GRP1_ROM [256] = '{
    8'hB1, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F,
    8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
    8'h18, 8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F,
    8'hB1, 8'h7E, 8'hF8, 8'h5E, 8'h60, 8'h27, 8'h22, 8'h27,
    8'hB1, 8'h2D, 8'hC4, 8'hB1, 8'hB1, 8'hB1, 8'h3C, 8'h3E,
    8'hB1, 8'h7E, 8'hF8, 8'h5E, 8'h60, 8'h27, 8'hB1, 8'h2C,
    8'h22, 8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'hB1,
    8'hB1, 8'hB1, 8'h98, 8'hB1, 8'hB1, 8'hB1, 8'hC6, 8'hC7,
    8'hDD, 8'hDE, 8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'hB1,
    8'hD0, 8'hD1, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD7,
    8'hD8, 8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hBD, 8'hBE, 8'hCF,
    8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'hFC, 8'h6C, 8'h4C, 8'hB1,
    8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'hB1,
    8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'hB1,
    8'hB1, 8'hB1, 8'hB1, 8'hB1, 8'h4B, 8'hA9, 8'h9C, 8'h9E,
    8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
    8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F,
    8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97,
    8'h98, 8'h99, 8'h9A, 8'h6F, 8'h9C, 8'h4F, 8'h78, 8'h9F,
    8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'hA7,
    8'hA8, 8'h54, 8'hAA, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF,
    8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hB4, 8'h41, 8'h41, 8'h41,
    8'h63, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'h9B, 8'h9D, 8'hBF,
    8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'h61, 8'h41,
    8'hC8, 8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hB1,
    8'h64, 8'h44, 8'h45, 8'h45, 8'h45, 8'h69, 8'h49, 8'h49,
    8'h49, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'h7C, 8'h49, 8'hDF,
    8'h4F, 8'hE1, 8'h4F, 8'h4F, 8'h6F, 8'h4F, 8'hE6, 8'h70,
    8'h50, 8'h55, 8'h55, 8'h55, 8'h79, 8'h59, 8'h5F, 8'h27,
    8'h2D, 8'hF1, 8'h3D, 8'hB1, 8'h14, 8'h15, 8'hF6, 8'h2C,
    8'hF8, 8'h22, 8'hF9, 8'h31, 8'h33, 8'hFD, 8'hFE, 8'hFF
  };

  // Total group length in bytes, prefix included, by prefix value.
  localparam logic [1:0] GRP_LEN_ROM [32] = '{
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1,
    2'd2, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2,
    2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
    2'd3, 2'd1, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
  };

endpackage

[sv/lmbcs_byte_stream_decoder.sv]
// Top level of the LMBCS byte-stream decoder: input stage, decode core, result register.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------------
//   input    | in_valid / in_ready   | src_byte, last_byte
//   output   | out_valid / out_ready | out_char, char_valid, stored, is_final,
//            |                       | char_count
//   config   | cfg_wr_en             | cfg_wr_data (dest_limit)
//
// The decoder takes one source beat per cycle while the output is not stalled and gives
// at most one result beat for it. A beat is held in the input register and decoded on
// its way into the result register, from which its result can be taken.
// Stalls on the output hold the result register and, through in_ready, the input
// register; the ready path runs combinationally from out_ready to in_ready.
// Synchronous reset empties both registers, returns the decoder to the start of a
// string with a zero count, and sets dest_limit to 65535.
module lmbcs_byte_stream_decoder import lmbcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  src_byte,
  input  logic        last_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        char_valid,
  output logic        stored,
  output logic        is_final,
  output logic [15:0] char_count,

  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] dest_limit;
  logic        held_valid;
  beat_t       held_beat;
  res_t        res;
  logic        out_free;
  logic        step;

  // The user must rewrite the storage limit only while the decoder is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      dest_limit <= cfg_wr_data;
    end
  end

  // The result register can be loaded when it is empty or being drained this cycle.
  assign out_free     = !out_valid || out_ready;
  // A held beat is decoded, and the string state advanced, when the result slot is free.
  assign step         = held_valid && out_free;

  lmbcs_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .src_byte   (src_byte),
    .last_byte  (last_byte),
    .advance    (out_free),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  lmbcs_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .beat       (held_beat),
    .dest_limit (dest_limit),
    .res        (res)
  );

  // Beats that decode to nothing (prefixes, skipped group bytes, bytes after NUL)
  // leave the result register empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_char   <= res.out_char;
      char_valid <= res.char_valid;
      stored     <= res.stored;
      is_final   <= res.is_final;
      char_count <= res.char_count;
    end
  end

endmodule

[sv/lmbcs_in_reg.sv]
// Input register stage of the LMBCS decoder: captures one source beat.
module lmbcs_in_reg import lmbcs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  [7:0] src_byte,
  input  logic  last_byte,
  input  logic  advance,
  output logic  held_valid,
  output beat_t held_beat
);

  // The slot takes a new beat when it is empty or its beat moves on now.
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_beat.src_byte  <= src_byte;
      held_beat.last_byte <= last_byte;
    end
  end

endmodule

[sv/lmbcs_core.sv]
// Decode logic and string state of the LMBCS decoder.
module lmbcs_core import lmbcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  beat_t       beat,
  input  logic [15:0] dest_limit,
  output res_t        res
);

  phase_t                phase, phase_next;
  logic [1:0]            skip_left, skip_left_next;
  logic [COUNT_BITS-1:0] char_total, char_total_next;

  logic                  valid_c;
  logic                  counts_c;
  logic                  ends_c;
  logic [7:0]            ch_c;
  logic [1:0]            rest_c;
  logic [CMP_BITS-1:0]   total_wide;

  always_comb begin
    phase_next      = phase;
    skip_left_next  = skip_left;
    char_total_next = char_total;
    valid_c         = 1'b0;
    counts_c        = 1'b1;
    ends_c          = 1'b0;
    ch_c            = 8'h00;
    rest_c          = GRP_LEN_ROM[beat.src_byte[4:0]] - 2'd1;
    res             = '0;

    unique case (phase)
      PH_DONE: begin
        // Everything after the terminator, the last beat included, is dropped.
        if (beat.last_byte) begin
          phase_next      = PH_NORMAL;
          skip_left_next  = '0;
          char_total_next = '0;
        end
      end
      PH_INDEX: begin
        ch_c       = GRP1_ROM[beat.src_byte];
        valid_c    = 1'b1;
        phase_next = PH_NORMAL;
      end
      PH_SKIP: begin
        if (skip_left != 2'd0) begin
          skip_left_next = skip_left - 2'd1;
        end
        if (skip_left_next == 2'd0) begin
          phase_next = PH_NORMAL;
        end
      end
      PH_NORMAL: begin
        priority if (beat.src_byte >= BYTE_PRINT_LO && beat.src_byte <= BYTE_PRINT_HI) begin
          ch_c    = beat.src_byte;
          valid_c = 1'b1;
        end else if (beat.src_byte == BYTE_NUL) begin
          valid_c  = 1'b1;
          counts_c = 1'b0;
          ends_c   = 1'b1;
        end else if (beat.src_byte == BYTE_GRP1_PFX) begin
          phase_next = PH_INDEX;
        end else if (beat.src_byte < BYTE_PRINT_LO) begin
          ch_c    = CHAR_UNKNOWN;
          valid_c = 1'b1;
          if (rest_c != 2'd0) begin
            skip_left_next = rest_c;
            phase_next     = PH_SKIP;
          end
        end else begin
          ch_c    = GRP1_ROM[beat.src_byte];
          valid_c = 1'b1;
        end
      end
      default: begin
        phase_next = PH_NORMAL;
      end
    endcase

    if (phase != PH_DONE) begin
      if (valid_c) begin
        res.stored = CMP_BITS'(char_total) < CMP_BITS'(dest_limit);
        if (counts_c && char_total != COUNT_MAX) begin
          char_total_next = char_total + 1'b1;
        end
      end

      total_wide     = CMP_BITS'(char_total_next);
      res.emit       = valid_c || beat.last_byte;
      res.out_char   = ch_c;
      res.char_valid = valid_c;
      res.is_final   = ends_c || beat.last_byte;
      res.char_count = (total_wide > CMP_BITS'(SHOW_MAX)) ? SHOW_MAX
                                                           : total_wide[SHOW_BITS-1:0];

      if (beat.last_byte) begin
        phase_next      = PH_NORMAL;
        skip_left_next  = '0;
        char_total_next = '0;
      end else if (ends_c) begin
        phase_next     = PH_DONE;
        skip_left_next = '0;
      end
    end else begin
      total_wide = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_NORMAL;
      skip_left  <= '0;
      char_total <= '0;
    end else if (step) begin
      phase      <= phase_next;
      skip_left  <= skip_left_next;
      char_total <= char_total_next;
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the LMBCS byte-stream decoder with random handshake idling.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmbcs_pkg::*;

  localparam int CLK_PERIOD     = 10;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;
  // Cycles the receiver refuses results during the back-pressure test.
  localparam int RX_HOLD_CYCLES = 80;
  // Settling time after the last result; covers the two-stage pipeline.
  localparam int DRAIN_CYCLES   = 6;
  localparam int MAX_REPORTS    = 200;

  // One source beat as offered on the input channel.
  typedef struct packed {
    logic [7:0] src;
    logic       last;
  } src_beat_t;

  // One decoded result beat, field by field as seen on the output channel.
  typedef struct packed {
    logic [7:0]  ch;
    logic        valid;
    logic        stored;
    logic        fin;
    logic [15:0] count;
  } char_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  src_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_char;
  logic        char_valid;
  logic        stored;
  logic        is_final;
  logic [15:0] char_count;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  // Source beats waiting to be offered, and decoded characters waiting to come out.
  src_beat_t   source_beats[$];
  char_res_t   pending_chars[$];

  // Decoder state as the testbench tracks it, plus its copy of dest_limit.
  phase_t                dec_phase = PH_NORMAL;
  logic [1:0]            dec_skip = '0;
  logic [COUNT_BITS-1:0] dec_total = '0;
  logic [15:0]           dest_limit_cfg = LIMIT_RESET;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold_reqs = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;
  int unsigned beats_queued = 0;
  int unsigned beats_in = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  lmbcs_byte_stream_decoder DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .src_byte    (src_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .char_valid  (char_valid),
    .stored      (stored),
    .is_final    (is_final),
    .char_count  (char_count),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Decodes one accepted source beat against the tracked state. Returns 1 when
  // the beat produces a result beat, which is then returned in res.
  function automatic bit decode_beat(input src_beat_t bt, output char_res_t res);
    logic [7:0]      b;
    logic [7:0]      ch;
    logic            produced;
    logic            counted;
    logic            ends;
    logic            st;
    logic [1:0]      rest;
    longint unsigned tot;
    b = bt.src;
    ch = '0;
    produced = 1'b0;
    counted = 1'b1;
    ends = 1'b0;
    st = 1'b0;
    res = '0;
    // Once a NUL has ended the string, everything up to the last byte is dropped
    // silently, and the last byte itself gives no result either.
    if (dec_phase == PH_DONE) begin
      if (bt.last) begin
        dec_phase = PH_NORMAL;
        dec_skip = '0;
        dec_total = '0;
      end
      return 1'b0;
    end
    case (dec_phase)
      PH_INDEX: begin
        ch = GRP1_ROM[b];
        produced = 1'b1;
        dec_phase = PH_NORMAL;
      end
      PH_SKIP: begin
        if (dec_skip != 0) dec_skip = dec_skip - 2'd1;
        if (dec_skip == 0) dec_phase = PH_NORMAL;
      end
      default: begin
        if (b >= BYTE_PRINT_LO && b <= BYTE_PRINT_HI) begin
          ch = b;
          produced = 1'b1;
        end else if (b == BYTE_NUL) begin
          produced = 1'b1;
          counted = 1'b0;
          ends = 1'b1;
        end else if (b == BYTE_GRP1_PFX) begin
          dec_phase = PH_INDEX;
        end else if (b < BYTE_PRINT_LO) begin
          // Any other group prefix stands for one unknown character and the
          // rest of its group is skipped.
          rest = GRP_LEN_ROM[b[4:0]] - 2'd1;
          ch = CHAR_UNKNOWN;
          produced = 1'b1;
          if (rest != 0) begin
            dec_skip = rest;
            dec_phase = PH_SKIP;
          end
        end else begin
          ch = GRP1_ROM[b];
          produced = 1'b1;
        end
      end
    endcase
    if (produced) begin
      st = (dec_total < dest_limit_cfg);
      if (counted && dec_total != COUNT_MAX) dec_total = dec_total + 1'b1;
    end
    if (!produced && !bt.last) return 1'b0;
    tot = 64'(dec_total);
    res.ch = ch;
    res.valid = produced;
    res.stored = st;
    res.fin = ends | bt.last;
    res.count = (tot > 64'(SHOW_MAX)) ? SHOW_MAX : tot[15:0];
    if (bt.last) begin
      dec_phase = PH_NORMAL;
      dec_skip = '0;
      dec_total = '0;
    end else if (ends) begin
      dec_phase = PH_DONE;
      dec_skip = '0;
    end
    return 1'b1;
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  // Sender. A beat is accepted when valid and ready are both high at an edge; the
  // accepted beat is decoded right there so the result order follows the input order.
  // A new beat is only put up once the previous one has gone, so valid and the
  // payload stay put while the block stalls.
  always @(posedge clk) begin
    src_beat_t cur;
    src_beat_t nxt;
    char_res_t res;
    if (rst) begin
      in_valid <= 1'b0;
      dec_phase = PH_NORMAL;
      dec_skip = '0;
      dec_total = '0;
    end else begin
      if (in_valid && in_ready) begin
        beats_in++;
        cur.src = src_byte;
        cur.last = last_byte;
        if (decode_beat(cur, res)) pending_chars.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (source_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = source_beats.pop_front();
          in_valid <= 1'b1;
          src_byte <= nxt.src;
          last_byte <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Every accepted result beat is checked against the oldest pending
  // character. A hold request from the stimulus makes the receiver refuse results
  // for a fixed stretch, counted here, so the block backs up into its input.
  always @(posedge clk) begin
    char_res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result beat with none pending, actual char 0x%0h count %0d",
                     $time, out_char, char_count);
        end else begin
          want = pending_chars.pop_front();
          compare_field("out_char", 32'(want.ch), 32'(out_char));
          compare_field("char_valid", 32'(want.valid), 32'(char_valid));
          compare_field("stored", 32'(want.stored), 32'(stored));
          compare_field("is_final", 32'(want.fin), 32'(is_final));
          compare_field("char_count", 32'(want.count), 32'(char_count));
        end
      end
      if (rx_hold_seen != rx_hold_reqs) begin
        rx_hold_seen = rx_hold_reqs;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog. Any beat on either channel restarts the count; a long silence means
  // the block has hung or lost a result.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results still pending",
               $time, WATCHDOG_LIMIT, pending_chars.size());
      $display("lmbcs_byte_stream_decoder: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_beat(input logic [7:0] b, input logic last);
    src_beat_t bt;
    bt.src = b;
    bt.last = last;
    source_beats.push_back(bt);
    beats_queued++;
  endtask

  // Queues one source string. Most strings are well formed with random content;
  // some are raw noise, and some are cut off in the middle of a group.
  task automatic add_string();
    int unsigned n;
    int unsigned i;
    int unsigned kind;
    int unsigned pick;
    logic [7:0]  pfx;
    kind = $urandom_range(99);
    if (kind < 12) begin
      n = $urandom_range(1, 8);
      repeat (n) add_beat(8'($urandom_range(255)), ($urandom_range(3) == 0));
      return;
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        add_beat(8'($urandom_range(BYTE_PRINT_LO, BYTE_PRINT_HI)), 1'b0);
      end else if (pick < 65) begin
        add_beat(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
      end else if (pick < 80) begin
        add_beat(BYTE_GRP1_PFX, 1'b0);
        add_beat(8'($urandom_range(255)), 1'b0);
      end else if (pick < 96) begin
        pfx = 8'($urandom_range(2, 31));
        add_beat(pfx, 1'b0);
        repeat (GRP_LEN_ROM[pfx[4:0]] - 1) add_beat(8'($urandom_range(255)), 1'b0);
      end else begin
        add_beat(BYTE_NUL, 1'b0);
      end
    end
    if (kind < 25) begin
      // The string stops inside a group: on the prefix or on a group byte.
      pfx = 8'($urandom_range(1, 31));
      if ($urandom_range(1) == 0) begin
        add_beat(pfx, 1'b1);
      end else begin
        add_beat(pfx, 1'b0);
        add_beat(8'($urandom_range(255)), 1'b1);
      end
    end else begin
      add_beat(8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic queue_strings(input int unsigned count);
    int unsigned goal;
    goal = beats_queued + count;
    while (beats_queued < goal) add_string();
  endtask

  // Returns once every queued beat is in and every pending character is out, then
  // gives trailing beats that produce nothing time to leave the pipeline.
  task automatic wait_drained();
    while (source_beats.size() != 0 || in_valid || pending_chars.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // dest_limit is only written with the block drained.
  task automatic write_limit(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dest_limit_cfg = value;
  endtask

  initial begin
    tx_idle_pct = 34;
    rx_idle_pct = 68;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed strings at the reset limit. Range ends of the pass-through and
    // table-mapped bytes first.
    add_beat(BYTE_PRINT_LO, 1'b0);
    add_beat(BYTE_PRINT_HI, 1'b0);
    add_beat(8'h80, 1'b0);
    add_beat(8'hFF, 1'b0);
    // Group-1 prefix followed by the lowest and highest table index.
    add_beat(BYTE_GRP1_PFX, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(BYTE_GRP1_PFX, 1'b0);
    add_beat(8'hFF, 1'b0);
    // Two-byte and three-byte groups whose tails are skipped, then a one-byte group.
    add_beat(8'h02, 1'b0);
    add_beat(8'h41, 1'b0);
    add_beat(8'h10, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h07, 1'b0);
    add_beat(8'h41, 1'b0);
    // A prefix on the last byte ends the string without reading its group.
    add_beat(8'h1F, 1'b1);
    // The last byte falls on a skipped group byte, so it ends with no character.
    add_beat(8'h10, 1'b0);
    add_beat(8'h55, 1'b1);
    // A group-1 prefix on the last byte gives no character either.
    add_beat(BYTE_GRP1_PFX, 1'b1);
    // NUL ends the string; the bytes after it, the last one too, are dropped.
    add_beat(8'h41, 1'b0);
    add_beat(BYTE_NUL, 1'b0);
    add_beat(8'h42, 1'b0);
    add_beat(8'hFF, 1'b1);
    // A NUL that is also the last byte.
    add_beat(BYTE_NUL, 1'b1);
    wait_drained();

    // Storage limit reached inside a string, then a count-only limit.
    write_limit(16'd2);
    add_beat(8'h61, 1'b0);
    add_beat(8'h62, 1'b0);
    add_beat(8'h63, 1'b1);
    wait_drained();
    write_limit(16'd0);
    add_beat(8'h78, 1'b0);
    add_beat(8'hE0, 1'b1);
    wait_drained();

    // Random strings, sender lightly idle and receiver mostly stalled. A long
    // receiver hold at the start lets the block fill up and stall its input.
    write_limit(16'($urandom_range(1, 20)));
    queue_strings(350);
    rx_hold_reqs++;
    wait_drained();

    // Roles swapped. Halfway through, the sender pauses until every pending
    // character has come out.
    tx_idle_pct = 68;
    rx_idle_pct = 34;
    write_limit(16'($urandom_range(0, 40)));
    queue_strings(175);
    wait_drained();
    queue_strings(175);
    wait_drained();

    // No idling on either side, full limit written explicitly.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_limit(16'hFFFF);
    queue_strings(320);
    wait_drained();

    $display("Covered %0d source beats and %0d result beats under three idle mixes,",
             beats_in, results_seen);
    $display("limits 0 through 65535, broken groups, NUL endings and a long output stall.");
    if (mismatches == 0) begin
      $display("lmbcs_byte_stream_decoder: match");
    end else begin
      $display("%0d field mismatches found.", mismatches);
      $display("lmbcs_byte_stream_decoder: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
sv/lmbcs_pkg.sv
sv/lmbcs_in_reg.sv
sv/lmbcs_core.sv
sv/lmbcs_byte_stream_decoder.sv
tb/tb.sv
